### src/aimd_cw_pkg.sv
// Shared types, constants and helpers for the AIMD congestion window block.
// No dependencies; used by every module in src.
package aimd_cw_pkg;

  // Default fixed-point format of the window
  localparam int FRAC_BITS_DEF  = 16;
  localparam int WHOLE_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN = 2'd2;

  // Register widths and reset values
  localparam int ALPHA_W    = 24;
  localparam int BETA_W     = 24;
  localparam int INIT_WIN_W = 16;

  localparam logic [ALPHA_W-1:0]    ALPHA_RST    = 24'd6554;   // about 0.1
  localparam logic [BETA_W-1:0]     BETA_RST     = 24'd98304;  // 1.5
  localparam logic [INIT_WIN_W-1:0] INIT_WIN_RST = 16'd10;

  // Result field widths
  localparam int OUT_FIELD_W = 16;

  // Event request and result
  typedef struct packed {
    logic kind;       // 0: acknowledgment, 1: datagram sent
    logic timed_out;
  } in_req_t;

  typedef struct packed {
    logic [OUT_FIELD_W-1:0] window_whole;
    logic [OUT_FIELD_W-1:0] window_fraction;
  } out_req_t;

  // Update applied to the window
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,   // send without timeout
    OP_ACK  = 2'd1,   // additive increase, alpha / window
    OP_CUT  = 2'd2    // multiplicative decrease, window / beta
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture dividend and divisor for a new request
    logic step;       // one restoring division step
    logic commit;     // write window and result register
    op_t  op;
  } cw_cmd_t;

  // Dividend width, which is also the number of divider steps
  function automatic int div_steps(input int frac_bits, input int whole_bits);
    int ack_w;
    int cut_w;
    ack_w = ALPHA_W + frac_bits;
    cut_w = whole_bits + 2 * frac_bits;
    return (ack_w > cut_w) ? ack_w : cut_w;
  endfunction

  // Decode an event into the window update it calls for
  function automatic op_t decode_op(input in_req_t req);
    op_t op;
    op = OP_HOLD;
    if (!req.kind) begin
      op = OP_ACK;
    end else if (req.timed_out) begin
      op = OP_CUT;
    end
    return op;
  endfunction

endpackage

### src/aimd_cw_dp.sv
// Datapath of the AIMD congestion window: configuration registers, window,
// shared restoring divider and result register. Depends on aimd_cw_pkg.
module aimd_cw_dp #(
  parameter int FRAC_BITS  = aimd_cw_pkg::FRAC_BITS_DEF,
  parameter int WHOLE_BITS = aimd_cw_pkg::WHOLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [aimd_cw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aimd_cw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  aimd_cw_pkg::cw_cmd_t                 cmd,
  output aimd_cw_pkg::out_req_t                out_data
);

  localparam int WIN_BITS = WHOLE_BITS + FRAC_BITS;
  localparam int DVD_BITS = aimd_cw_pkg::div_steps(FRAC_BITS, WHOLE_BITS);
  localparam int DIV_BITS = (WIN_BITS > aimd_cw_pkg::BETA_W) ? WIN_BITS
                                                             : aimd_cw_pkg::BETA_W;
  localparam int OW       = aimd_cw_pkg::OUT_FIELD_W;

  localparam logic [WIN_BITS-1:0] WIN_ONE   = WIN_BITS'(1) << FRAC_BITS;
  localparam logic [WIN_BITS-1:0] WIN_MAX   = '1;
  localparam logic [DIV_BITS-1:0] DIV_ONE   = DIV_BITS'(1) << FRAC_BITS;
  localparam logic [32:0]         MAX_WHOLE = (33'd1 << WHOLE_BITS) - 33'd1;

  // Whole number to window: zero loads 1.0, too large saturates
  function automatic logic [WIN_BITS-1:0] whole_to_window(
    input logic [aimd_cw_pkg::INIT_WIN_W-1:0] whole
  );
    logic [aimd_cw_pkg::INIT_WIN_W-1:0] w;
    logic [WIN_BITS-1:0]                res;
    w = (whole == '0) ? aimd_cw_pkg::INIT_WIN_W'(1) : whole;
    if (33'(w) > MAX_WHOLE) begin
      res = WIN_MAX;
    end else begin
      res = WIN_BITS'(w) << FRAC_BITS;
    end
    return res;
  endfunction

  logic [aimd_cw_pkg::ALPHA_W-1:0] alpha_r;
  logic [aimd_cw_pkg::BETA_W-1:0]  beta_r;
  logic [WIN_BITS-1:0]             win_r;
  logic [DVD_BITS-1:0]             dvd_r, dvd_nxt;   // dividend in, quotient out
  logic [DIV_BITS-1:0]             rem_r, rem_nxt;
  logic [DIV_BITS-1:0]             div_r, div_nxt;
  aimd_cw_pkg::out_req_t           out_r, out_nxt;

  logic [WIN_BITS-1:0] win_c;
  logic [DIV_BITS-1:0] beta_c;
  logic [DIV_BITS:0]   rem_sh;
  logic [DIV_BITS:0]   rem_sub;
  logic                rem_ge;
  logic [DVD_BITS:0]   ack_sum;
  logic [WIN_BITS-1:0] win_upd;
  logic [WIN_BITS-1:0] win_hi;
  logic [WIN_BITS-1:0] win_lo;

  always_comb begin
    win_c  = (win_r < WIN_ONE) ? WIN_ONE : win_r;
    beta_c = (DIV_BITS'(beta_r) < DIV_ONE) ? DIV_ONE : DIV_BITS'(beta_r);

    // One restoring step
    rem_sh  = {rem_r, dvd_r[DVD_BITS-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    rem_ge  = (rem_sh >= {1'b0, div_r});

    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    if (cmd.load) begin
      rem_nxt = '0;
      if (cmd.op == aimd_cw_pkg::OP_ACK) begin
        dvd_nxt = DVD_BITS'(alpha_r) << FRAC_BITS;
        div_nxt = DIV_BITS'(win_c);
      end else begin
        dvd_nxt = DVD_BITS'(win_c) << FRAC_BITS;
        div_nxt = beta_c;
      end
    end else if (cmd.step) begin
      dvd_nxt = {dvd_r[DVD_BITS-2:0], rem_ge};
      rem_nxt = rem_ge ? rem_sub[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
    end

    // Window update from the finished quotient
    ack_sum = (DVD_BITS + 1)'(win_c) + {1'b0, dvd_r};
    unique case (cmd.op)
      aimd_cw_pkg::OP_ACK: begin
        win_upd = (ack_sum > (DVD_BITS + 1)'(WIN_MAX)) ? WIN_MAX
                                                       : ack_sum[WIN_BITS-1:0];
      end
      aimd_cw_pkg::OP_CUT: begin
        if (dvd_r < DVD_BITS'(WIN_ONE)) begin
          win_upd = WIN_ONE;
        end else if (dvd_r > DVD_BITS'(WIN_MAX)) begin
          win_upd = WIN_MAX;
        end else begin
          win_upd = dvd_r[WIN_BITS-1:0];
        end
      end
      default: win_upd = win_c;
    endcase

    win_hi = win_upd >> FRAC_BITS;
    win_lo = win_upd & (WIN_ONE - WIN_BITS'(1));
    out_nxt.window_whole    = win_hi[OW-1:0];
    out_nxt.window_fraction = win_lo[OW-1:0];
  end

  // Configuration and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= aimd_cw_pkg::ALPHA_RST;
      beta_r  <= aimd_cw_pkg::BETA_RST;
      win_r   <= whole_to_window(aimd_cw_pkg::INIT_WIN_RST);
    end else begin
      if (cmd.commit) begin
        win_r <= win_upd;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          aimd_cw_pkg::CFG_ALPHA:    alpha_r <= cfg_wdata[aimd_cw_pkg::ALPHA_W-1:0];
          aimd_cw_pkg::CFG_BETA:     beta_r  <= cfg_wdata[aimd_cw_pkg::BETA_W-1:0];
          aimd_cw_pkg::CFG_INIT_WIN: begin
            win_r <= whole_to_window(cfg_wdata[aimd_cw_pkg::INIT_WIN_W-1:0]);
          end
          default: ;
        endcase
      end
    end
  end

  // Divider and result payload
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

### src/aimd_cw_ctrl.sv
// Controller of the AIMD congestion window: request handshake, divider step
// counter and result handshake. Depends on aimd_cw_pkg.
module aimd_cw_ctrl #(
  parameter int FRAC_BITS  = aimd_cw_pkg::FRAC_BITS_DEF,
  parameter int WHOLE_BITS = aimd_cw_pkg::WHOLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  aimd_cw_pkg::in_req_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output aimd_cw_pkg::cw_cmd_t  cmd
);

  localparam int DVD_BITS = aimd_cw_pkg::div_steps(FRAC_BITS, WHOLE_BITS);
  localparam int CNT_W    = $clog2(DVD_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  aimd_cw_pkg::op_t     op_r, op_nxt;
  logic                 out_valid_r, out_valid_nxt;
  aimd_cw_pkg::op_t     in_op;
  logic                 accept;
  logic                 out_free;

  always_comb begin
    in_op    = aimd_cw_pkg::decode_op(in_data);
    accept   = in_valid && (state_r == ST_IDLE);
    out_free = !out_valid_r || !out_stall;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && out_stall;

    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    cmd.op     = op_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.op   = in_op;
          op_nxt   = in_op;
          cnt_nxt  = CNT_W'(DVD_BITS);
          // A send without timeout needs no division
          state_nxt = (in_op == aimd_cw_pkg::OP_HOLD) ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold the finished update until the result register is free
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      op_r        <= aimd_cw_pkg::OP_HOLD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // A commit never overwrites a result that is still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("commit over a pending result");

  // Every commit presents a result in the next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  // A result appears only from a commit
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result valid without commit");

  // The divider never runs with an exhausted step count
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r != '0))
    else $error("divider running with zero steps left");

  // A division request always passes through the divider steps
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op != aimd_cw_pkg::OP_HOLD)) |=> (state_r == ST_RUN))
    else $error("division request skipped the divider");

endmodule

### src/aimd_congestion_window.sv
// Top level of the AIMD congestion window block.
// Depends on aimd_cw_pkg, aimd_cw_ctrl and aimd_cw_dp.
//
// Usage
//   Input channel (in_valid / in_stall / in_data): one request per event,
//   kind 0 for an acknowledgment, kind 1 for a datagram sent, with timed_out
//   marking a send caused by a timeout.
//   Result channel (out_valid / out_stall / out_data): one result per request,
//   the window's whole and fractional parts after the update.
//   Configuration port (cfg_we / cfg_index / cfg_wdata): alpha, beta and
//   initial window; writing the initial window reloads the window at once.
//   Write configuration only while no request is in flight.
// Timing
//   A request needing a division (acknowledgment or timed-out send) passes
//   through the divider after acceptance. DVD is the dividend width
//   max(24 + FRAC_BITS, WHOLE_BITS + 2 * FRAC_BITS), 48 by default. The
//   shared restoring divider retires one quotient bit per cycle. A send
//   without timeout skips the divider. One request is worked on at a time:
//   a new request is taken only once the last one's update is committed.
// Reset and stall
//   Synchronous reset loads alpha 0.1, beta 1.5 and a window of 10.0 and
//   empties the result register. The result register frees the input side:
//   a new request is accepted while a result waits, but its update is held
//   back until the pending result is taken.
module aimd_congestion_window #(
  parameter int FRAC_BITS  = aimd_cw_pkg::FRAC_BITS_DEF,
  parameter int WHOLE_BITS = aimd_cw_pkg::WHOLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  aimd_cw_pkg::in_req_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output aimd_cw_pkg::out_req_t               out_data,
  input  logic                                cfg_we,
  input  logic [aimd_cw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aimd_cw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  aimd_cw_pkg::cw_cmd_t cmd;

  // Sequence each request: load, divide, commit
  aimd_cw_ctrl #(
    .FRAC_BITS  (FRAC_BITS),
    .WHOLE_BITS (WHOLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Window, registers, divider and result payload
  aimd_cw_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .WHOLE_BITS (WHOLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule
